>>> hdl/lmtc_pkg.sv
package lmtc_pkg;

  localparam int unsigned CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    REG_KEY_PERIOD    = 3'd0,
    REG_BLINK_PERIOD  = 3'd1,
    REG_LAMP_PERIOD   = 3'd2,
    REG_CHARGE_PERIOD = 3'd3,
    REG_DEBOUNCE      = 3'd4,
    REG_LAMP_SECONDS  = 3'd5
  } reg_index_t;

  localparam logic [15:0] KEY_PERIOD_RST    = 16'd1;
  localparam logic [15:0] BLINK_PERIOD_RST  = 16'd1000;
  localparam logic [15:0] LAMP_PERIOD_RST   = 16'd1000;
  localparam logic [15:0] CHARGE_PERIOD_RST = 16'd500;
  localparam logic [15:0] DEBOUNCE_RST      = 16'd60;
  localparam logic [15:0] LAMP_SECONDS_RST  = 16'd600;

  localparam int unsigned TaskKey    = 0;
  localparam int unsigned TaskBlink  = 1;
  localparam int unsigned TaskLamp   = 2;
  localparam int unsigned TaskCharge = 3;
  localparam int unsigned TaskCount  = 4;

  localparam logic [2:0] CODE_INIT    = 3'd0;
  localparam logic [2:0] CODE_OPEN    = 3'd1;
  localparam logic [2:0] CODE_WHITE   = 3'd2;
  localparam logic [2:0] CODE_CLOSE   = 3'd3;
  localparam logic [2:0] CODE_STANDBY = 3'd4;

  typedef enum logic [4:0] {
    MENU_INIT    = 5'b00001,
    MENU_OPEN    = 5'b00010,
    MENU_WHITE   = 5'b00100,
    MENU_CLOSE   = 5'b01000,
    MENU_STANDBY = 5'b10000
  } menu_t;

  function automatic logic [2:0] menu_code(input menu_t m);
    logic [2:0] c;
    case (m)
      MENU_INIT:    c = CODE_INIT;
      MENU_OPEN:    c = CODE_OPEN;
      MENU_WHITE:   c = CODE_WHITE;
      MENU_CLOSE:   c = CODE_CLOSE;
      MENU_STANDBY: c = CODE_STANDBY;
      default:      c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/lamp_menu_tick_controller.sv
// one request per 1 ms tick, one result per request
// the result is registered in the cycle after the request is accepted
// throughput: one request per cycle, limited only by out_stall
// the combinational task dispatch path sets this rate
// rst (synchronous): config registers and task counters back to defaults, menu to init,
// work and error pins high, result register empty
module lamp_menu_tick_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 key_level,
  input  logic                                 charging_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 work_led,
  output logic                                 error_led,
  output logic                                 white_lamp,
  output logic [2:0]                           menu_state,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lmtc_pkg::CfgAddrWidth-1:0]    paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [15:0] key_period, blink_period, lamp_period, charge_period;
  logic [15:0] debounce_limit, lamp_on_seconds;

  logic [15:0] task_left [lmtc_pkg::TaskCount];
  logic [15:0] task_left_next [lmtc_pkg::TaskCount];
  logic [15:0] period [lmtc_pkg::TaskCount];
  logic [lmtc_pkg::TaskCount-1:0] task_pending, task_pending_next;

  lmtc_pkg::menu_t menu_mode, menu_mode_next;
  logic        previous_key, previous_charge, previous_charge_next;
  logic [15:0] press_ticks, press_ticks_next;
  logic        press_latched, press_latched_next;
  logic        blink_enabled, blink_enabled_next;
  logic        blink_phase, blink_phase_next;
  logic        work_pin, work_pin_next;
  logic        error_pin, error_pin_next;
  logic        lamp_request, lamp_request_next;
  logic [15:0] lamp_seconds_left, lamp_seconds_left_next;
  logic        lamp_on, lamp_on_next;

  logic in_accept;
  logic cfg_write;
  logic [2:0] reg_sel;
  logic press;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_sel   = paddr[4:2];
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign period[lmtc_pkg::TaskKey]    = key_period;
  assign period[lmtc_pkg::TaskBlink]  = blink_period;
  assign period[lmtc_pkg::TaskLamp]   = lamp_period;
  assign period[lmtc_pkg::TaskCharge] = charge_period;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_period      <= lmtc_pkg::KEY_PERIOD_RST;
      blink_period    <= lmtc_pkg::BLINK_PERIOD_RST;
      lamp_period     <= lmtc_pkg::LAMP_PERIOD_RST;
      charge_period   <= lmtc_pkg::CHARGE_PERIOD_RST;
      debounce_limit  <= lmtc_pkg::DEBOUNCE_RST;
      lamp_on_seconds <= lmtc_pkg::LAMP_SECONDS_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        lmtc_pkg::REG_KEY_PERIOD:    key_period      <= pwdata[15:0];
        lmtc_pkg::REG_BLINK_PERIOD:  blink_period    <= pwdata[15:0];
        lmtc_pkg::REG_LAMP_PERIOD:   lamp_period     <= pwdata[15:0];
        lmtc_pkg::REG_CHARGE_PERIOD: charge_period   <= pwdata[15:0];
        lmtc_pkg::REG_DEBOUNCE:      debounce_limit  <= pwdata[15:0];
        lmtc_pkg::REG_LAMP_SECONDS:  lamp_on_seconds <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lmtc_pkg::REG_KEY_PERIOD:    prdata = {16'd0, key_period};
      lmtc_pkg::REG_BLINK_PERIOD:  prdata = {16'd0, blink_period};
      lmtc_pkg::REG_LAMP_PERIOD:   prdata = {16'd0, lamp_period};
      lmtc_pkg::REG_CHARGE_PERIOD: prdata = {16'd0, charge_period};
      lmtc_pkg::REG_DEBOUNCE:      prdata = {16'd0, debounce_limit};
      lmtc_pkg::REG_LAMP_SECONDS:  prdata = {16'd0, lamp_on_seconds};
      default:                     prdata = 32'd0;
    endcase
  end

  // one tick: wake, counters, dispatch
  always_comb begin
    menu_mode_next         = menu_mode;
    task_pending_next      = task_pending;
    press_ticks_next       = press_ticks;
    press_latched_next     = press_latched;
    blink_enabled_next     = blink_enabled;
    blink_phase_next       = blink_phase;
    work_pin_next          = work_pin;
    error_pin_next         = error_pin;
    lamp_request_next      = lamp_request;
    lamp_seconds_left_next = lamp_seconds_left;
    lamp_on_next           = lamp_on;
    previous_charge_next   = previous_charge;
    press                  = 1'b0;

    if (previous_key && !key_level &&
        (menu_mode == lmtc_pkg::MENU_CLOSE || menu_mode == lmtc_pkg::MENU_STANDBY)) begin
      menu_mode_next = lmtc_pkg::MENU_INIT;
    end

    for (int i = 0; i < lmtc_pkg::TaskCount; i++) begin
      task_left_next[i] = task_left[i] - 16'd1;
      if (task_left_next[i] == 16'd0) begin
        task_left_next[i]    = period[i];
        task_pending_next[i] = 1'b1;
      end
    end

    if (menu_mode_next != lmtc_pkg::MENU_STANDBY) begin
      if (task_pending_next[lmtc_pkg::TaskKey]) begin
        task_pending_next[lmtc_pkg::TaskKey] = 1'b0;
        if (!key_level) begin
          if (!press_latched) begin
            press_ticks_next = press_ticks + 16'd1;
            if (press_ticks_next >= debounce_limit) begin
              press_latched_next = 1'b1;
              press              = 1'b1;
            end
          end
        end else begin
          press_ticks_next   = 16'd0;
          press_latched_next = 1'b0;
        end

        if (press) begin
          case (menu_mode_next)
            lmtc_pkg::MENU_INIT: begin
              menu_mode_next     = lmtc_pkg::MENU_OPEN;
              blink_enabled_next = 1'b1;
            end
            lmtc_pkg::MENU_OPEN: begin
              menu_mode_next     = lmtc_pkg::MENU_WHITE;
              lamp_request_next  = 1'b1;
              blink_enabled_next = 1'b1;
            end
            lmtc_pkg::MENU_WHITE: begin
              menu_mode_next     = lmtc_pkg::MENU_CLOSE;
              blink_enabled_next = 1'b0;
              lamp_on_next       = 1'b0;
              work_pin_next      = 1'b0;
            end
            default: begin
              menu_mode_next     = lmtc_pkg::MENU_OPEN;
              blink_enabled_next = 1'b1;
            end
          endcase
        end

        // init after a key step: work pin goes high; error is driven low just below
        if (menu_mode_next == lmtc_pkg::MENU_INIT) begin
          work_pin_next = 1'b1;
        end
      end

      error_pin_next = 1'b0;

      if (menu_mode_next == lmtc_pkg::MENU_CLOSE) begin
        menu_mode_next = lmtc_pkg::MENU_STANDBY;
      end else begin
        if (task_pending_next[lmtc_pkg::TaskBlink]) begin
          task_pending_next[lmtc_pkg::TaskBlink] = 1'b0;
          if (blink_enabled_next) begin
            work_pin_next    = ~blink_phase;
            blink_phase_next = ~blink_phase;
          end
        end

        if (task_pending_next[lmtc_pkg::TaskLamp]) begin
          task_pending_next[lmtc_pkg::TaskLamp] = 1'b0;
          if (lamp_request_next) begin
            lamp_request_next      = 1'b0;
            lamp_seconds_left_next = lamp_on_seconds;
            lamp_on_next           = 1'b1;
          end
          if (lamp_seconds_left_next != 16'd0) begin
            lamp_seconds_left_next = lamp_seconds_left_next - 16'd1;
            if (lamp_seconds_left_next == 16'd0) begin
              lamp_on_next = 1'b0;
            end
          end
        end

        if (task_pending_next[lmtc_pkg::TaskCharge]) begin
          task_pending_next[lmtc_pkg::TaskCharge] = 1'b0;
          if (menu_mode_next != lmtc_pkg::MENU_INIT) begin
            if (previous_charge && !charging_level) begin
              lamp_request_next = 1'b1;
            end
            previous_charge_next = charging_level;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_left[lmtc_pkg::TaskKey]    <= lmtc_pkg::KEY_PERIOD_RST;
      task_left[lmtc_pkg::TaskBlink]  <= lmtc_pkg::BLINK_PERIOD_RST;
      task_left[lmtc_pkg::TaskLamp]   <= lmtc_pkg::LAMP_PERIOD_RST;
      task_left[lmtc_pkg::TaskCharge] <= lmtc_pkg::CHARGE_PERIOD_RST;
      task_pending      <= '0;
      menu_mode         <= lmtc_pkg::MENU_INIT;
      previous_key      <= 1'b1;
      previous_charge   <= 1'b1;
      press_ticks       <= 16'd0;
      press_latched     <= 1'b0;
      blink_enabled     <= 1'b0;
      blink_phase       <= 1'b0;
      work_pin          <= 1'b1;
      error_pin         <= 1'b1;
      lamp_request      <= 1'b0;
      lamp_seconds_left <= 16'd0;
      lamp_on           <= 1'b0;
    end else if (in_accept) begin
      for (int i = 0; i < lmtc_pkg::TaskCount; i++) begin
        task_left[i] <= task_left_next[i];
      end
      task_pending      <= task_pending_next;
      menu_mode         <= menu_mode_next;
      previous_key      <= key_level;
      previous_charge   <= previous_charge_next;
      press_ticks       <= press_ticks_next;
      press_latched     <= press_latched_next;
      blink_enabled     <= blink_enabled_next;
      blink_phase       <= blink_phase_next;
      work_pin          <= work_pin_next;
      error_pin         <= error_pin_next;
      lamp_request      <= lamp_request_next;
      lamp_seconds_left <= lamp_seconds_left_next;
      lamp_on           <= lamp_on_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      work_led   <= work_pin_next;
      error_led  <= error_pin_next;
      white_lamp <= lamp_on_next;
      menu_state <= lmtc_pkg::menu_code(menu_mode_next);
    end
  end

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_close_is_transient: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> menu_state != lmtc_pkg::CODE_CLOSE)
    else $error("close mode visible in a result");

  a_standby_lamp_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && menu_state == lmtc_pkg::CODE_STANDBY |-> !white_lamp)
    else $error("white lamp lit in standby");

  a_error_low_when_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && menu_state != lmtc_pkg::CODE_STANDBY |-> !error_led)
    else $error("error led high outside standby");

endmodule
